// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file srt_checker
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is low
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define CHK_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/srt_pkg.sv -----
// shared constants, types and helpers of the shortest-remaining-time scheduler
// no dependencies

`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

    localparam int MAX_PROCS = 16;
    localparam int SLOT_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int ARR_W   = 16;
    localparam int BUR_W   = 16;
    localparam int TIME_W  = 32;
    localparam int ID_W    = 5;
    localparam int ENTRY_W = ARR_W + 2 * BUR_W;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 2;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_UPDATE = 5'b00100,
        S_TAT    = 5'b01000,
        S_EMIT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic update;
        logic tat;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_dp_sts;

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == TIME_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- sv/shortest_remaining_time_scheduler.sv -----
// channel   dir  handshake              payload
// s (in)    in   i_s_tvalid/o_s_tready  tdata {burst, arrival}, tuser opcode
// m (out)   out  o_m_tvalid/i_m_tready  tdata {all_done, wait, tat, comp, id}, tuser flags
//
// a load is absorbed in its transfer cycle and gives no result
// a tick runs the minimum scan, one table ram read per cycle, then the update,
// turnaround and result steps
// the result register holds until taken; a new item is accepted meanwhile
// i_rst_n is synchronous, active low; the job table needs no clearing
// top level of the scheduler; depends on srt_pkg, srt_ctrl, srt_dp, srt_ram

`timescale 1ns / 1ps
`default_nettype none

module shortest_remaining_time_scheduler
    import srt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,   // arrival_time[15:0], burst_time[31:16]
    input  wire logic                i_s_tuser,   // opcode
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic      [M_DATA_W-1:0] o_m_tdata,   // job_id[4:0], completion_time[36:5],
                                                  // turnaround_time[68:37],
                                                  // waiting_time[100:69], all_done[101]
    output logic      [M_USER_W-1:0] o_m_tuser    // job_ran[0], job_finished[1]
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    srt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_opcode   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    srt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

// ----- sv/srt_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

`timescale 1ns / 1ps
`default_nettype none

module srt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/srt_ctrl.sv -----
// controller state machine of the scheduler: sequences load, scan, update, turnaround, emit
// depends on srt_pkg

`timescale 1ns / 1ps
`default_nettype none

module srt_ctrl
    import srt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_opcode,
    output logic         o_s_tready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_opcode == OP_TICK) begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_UPDATE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_TAT;
            end
            S_TAT: begin
                o_cmd.tat = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/srt_dp.sv -----
// datapath of the scheduler: job table, minimum scan, time keeping, result register
// depends on srt_pkg and srt_ram

`timescale 1ns / 1ps
`default_nettype none

module srt_dp
    import srt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_sts                  o_sts,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    output logic      [M_DATA_W-1:0] o_m_tdata,
    output logic      [M_USER_W-1:0] o_m_tuser
);

    logic [CNT_W-1:0]  r_loaded;
    logic [CNT_W-1:0]  r_finished;
    logic [TIME_W-1:0] r_time;
    logic [CNT_W-1:0]  r_idx;
    logic              r_pend;
    logic              r_found;
    logic              r_out_valid;

    logic [SLOT_W-1:0] r_best;
    logic [BUR_W-1:0]  r_best_rem;
    logic [ARR_W-1:0]  r_best_arr;
    logic [BUR_W-1:0]  r_best_bur;
    logic              r_fin;
    logic [TIME_W-1:0] r_comp;
    logic [TIME_W-1:0] r_tat;

    logic [ARR_W-1:0]   w_in_arr;
    logic [BUR_W-1:0]   w_in_bur;
    logic               w_load_ok;
    logic               w_we;
    logic [SLOT_W-1:0]  w_waddr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;
    logic [ARR_W-1:0]   w_rd_arr;
    logic [BUR_W-1:0]   w_rd_bur;
    logic [BUR_W-1:0]   w_rd_rem;
    logic               w_better;
    logic               w_more;
    logic [TIME_W-1:0]  w_time_inc;
    logic [31:0]        w_id_wide;
    logic [ID_W-1:0]    w_id;
    logic [TIME_W-1:0]  w_wait;

    assign w_in_arr = i_s_tdata[ARR_W-1:0];
    assign w_in_bur = i_s_tdata[ARR_W+BUR_W-1:ARR_W];
    assign w_load_ok = i_cmd.load && (w_in_bur != '0) && (r_loaded < CNT_W'(MAX_PROCS));

    assign w_rd_arr = w_rdata[ENTRY_W-1:2*BUR_W];
    assign w_rd_bur = w_rdata[2*BUR_W-1:BUR_W];
    assign w_rd_rem = w_rdata[BUR_W-1:0];

    assign w_we    = w_load_ok || (i_cmd.update && r_found);
    assign w_waddr = i_cmd.update ? r_best : r_loaded[SLOT_W-1:0];
    assign w_wdata = i_cmd.update ? {r_best_arr, r_best_bur, r_best_rem - 1'b1}
                                  : {w_in_arr, w_in_bur, w_in_bur};

    srt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_more   = r_idx < r_loaded;
    assign w_better = r_pend && ({{(TIME_W-ARR_W){1'b0}}, w_rd_arr} <= r_time) &&
                      (w_rd_rem != '0) && (!r_found || (w_rd_rem < r_best_rem));
    assign w_time_inc = sat_inc(r_time);

    assign o_sts.scan_done = !r_pend && !w_more;
    assign o_sts.out_free  = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded    <= '0;
            r_finished  <= '0;
            r_time      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load_ok) begin
                r_loaded <= r_loaded + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_idx   <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_pend <= w_more;
                if (w_more) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (w_better) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.update) begin
                r_time <= w_time_inc;
                if (r_found && (r_best_rem == BUR_W'(1))) begin
                    r_finished <= r_finished + 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // scan bookkeeping and result timing
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && w_better) begin
            r_best     <= SLOT_W'(r_idx - 1'b1);
            r_best_rem <= w_rd_rem;
            r_best_arr <= w_rd_arr;
            r_best_bur <= w_rd_bur;
        end
        if (i_cmd.update) begin
            r_fin  <= r_found && (r_best_rem == BUR_W'(1));
            r_comp <= w_time_inc;
        end
        if (i_cmd.tat) begin
            r_tat <= r_comp - {{(TIME_W-ARR_W){1'b0}}, r_best_arr};
        end
    end

    assign w_id_wide = 32'(r_best) + 32'd1;
    assign w_id      = r_found ? w_id_wide[ID_W-1:0] : '0;
    assign w_wait    = (r_tat >= {{(TIME_W-BUR_W){1'b0}}, r_best_bur}) ?
                       (r_tat - {{(TIME_W-BUR_W){1'b0}}, r_best_bur}) : '0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_m_tuser <= {r_fin, r_found};
            o_m_tdata <= {2'b00,
                          r_finished == r_loaded,
                          r_fin ? w_wait : '0,
                          r_fin ? r_tat : '0,
                          r_fin ? r_comp : '0,
                          w_id};
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

`default_nettype wire

// ----- sv/srt_checker.sv -----
// port-level checks of the scheduler, bound to the top level
// depends on srt_pkg and assert_macros.svh

`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module srt_checker
    import srt_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_m_tvalid,
    input wire logic                i_m_tready,
    input wire logic [M_DATA_W-1:0] o_m_tdata,
    input wire logic [M_USER_W-1:0] o_m_tuser
);

    `CHK_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "stalled result changed")
    `CHK_ASSERT(a_idle_zero, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[100:0] == '0, "idle tick carries data")
    `CHK_ASSERT(a_fin_ran, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0], "finish without a run")
    `CHK_ASSERT(a_wait_le_tat, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[1] |-> o_m_tdata[100:69] <= o_m_tdata[68:37], "waiting exceeds turnaround")
    `CHK_ASSERT_NR(a_rst_clear, i_clk, !i_rst_n |=> !o_m_tvalid, "result valid after reset")

endmodule

bind shortest_remaining_time_scheduler srt_checker u_chk (.*);

`default_nettype wire

// ----- test/shortest_remaining_time_scheduler_test.sv -----
// testbench of shortest_remaining_time_scheduler: loads and ticks are checked against a
// predicted job table; every tick result is compared field by field in arrival order
// depends on srt_pkg and the scheduler rtl

`timescale 1ns / 1ps

module shortest_remaining_time_scheduler_test;
    import srt_pkg::*;

    typedef struct packed {
        logic              ran;
        logic [ID_W-1:0]   id;
        logic              finished;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waited;
        logic              all_done;
    } t_tick_report;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata = '0;   // arrival_time, burst_time
    logic                i_s_tuser = 1'b0; // opcode
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;        // job_id, completion, turnaround, waiting, all_done
    logic [M_USER_W-1:0] o_m_tuser;        // job_ran, job_finished

    // predicted job table
    logic [ARR_W-1:0]  arrival_tab [MAX_PROCS];
    logic [BUR_W-1:0]  burst_tab   [MAX_PROCS];
    logic [BUR_W-1:0]  left_tab    [MAX_PROCS];
    int                jobs_held;
    int                jobs_done;
    logic [TIME_W-1:0] cur_time;

    t_tick_report pending_reports[$];

    int idle_pct;
    int errors;
    int loads_sent;
    int ticks_sent;
    int idle_ticks;
    int reports_seen;

    shortest_remaining_time_scheduler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic schedule_item(input logic op, input logic [ARR_W-1:0] arr,
                                 input logic [BUR_W-1:0] bur);
        t_tick_report      rpt;
        int                pick;
        logic [BUR_W-1:0]  least;
        logic [TIME_W-1:0] done_at;
        logic [TIME_W-1:0] tat;
        if (op == OP_LOAD) begin
            loads_sent++;
            if (bur != '0 && jobs_held < MAX_PROCS) begin
                arrival_tab[jobs_held] = arr;
                burst_tab[jobs_held]   = bur;
                left_tab[jobs_held]    = bur;
                jobs_held++;
            end
            return;
        end
        ticks_sent++;
        pick  = -1;
        least = '0;
        rpt   = '0;
        for (int s = 0; s < jobs_held; s++) begin
            if (arrival_tab[s] <= cur_time && left_tab[s] != '0 &&
                (pick < 0 || left_tab[s] < least)) begin
                pick  = s;
                least = left_tab[s];
            end
        end
        if (pick >= 0) begin
            rpt.ran = 1'b1;
            rpt.id  = ID_W'(pick + 1);
            left_tab[pick] = least - 1'b1;
            if (left_tab[pick] == '0) begin
                done_at = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
                tat     = done_at - arrival_tab[pick];
                rpt.finished   = 1'b1;
                rpt.completion = done_at;
                rpt.turnaround = tat;
                rpt.waited     = (tat >= burst_tab[pick]) ? tat - burst_tab[pick] : '0;
                jobs_done++;
            end
        end else begin
            idle_ticks++;
        end
        cur_time = (cur_time == TIME_MAX) ? cur_time : cur_time + 1'b1;
        rpt.all_done = (jobs_done == jobs_held);
        pending_reports.insert(pending_reports.size(), rpt);
    endtask

    task automatic send_item(input logic op, input logic [ARR_W-1:0] arr,
                             input logic [BUR_W-1:0] bur);
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {bur, arr};
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        schedule_item(op, arr, bur);
    endtask

    task automatic send_tick();
        send_item(OP_TICK, ARR_W'($urandom), BUR_W'($urandom));
    endtask

    task automatic wait_for_reports();
        i_s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_report();
        t_tick_report want;
        reports_seen++;
        if (pending_reports.size() == 0) begin
            $error("result transfer with no tick pending: tdata %0h", o_m_tdata);
            errors++;
            return;
        end
        want = pending_reports.pop_front();
        check_field("job_ran", want.ran, o_m_tuser[0]);
        check_field("job_id", want.id, o_m_tdata[4:0]);
        check_field("job_finished", want.finished, o_m_tuser[1]);
        check_field("completion_time", want.completion, o_m_tdata[36:5]);
        check_field("turnaround_time", want.turnaround, o_m_tdata[68:37]);
        check_field("waiting_time", want.waited, o_m_tdata[100:69]);
        check_field("all_done", want.all_done, o_m_tdata[101]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            check_report();
        end
        i_m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // idle ticks, zero-burst loads, all_done on an empty table
    task automatic test_empty_table();
        send_tick();
        send_item(OP_LOAD, 16'hFFFF, 16'h0000);
        send_item(OP_LOAD, 16'h0000, 16'h0000);
        send_tick();
    endtask

    // ties, preemption by a shorter arrival, late load, then a full drain
    task automatic test_preemption();
        send_item(OP_LOAD, 16'd0, 16'd4);
        send_item(OP_LOAD, 16'd0, 16'd4);
        send_item(OP_LOAD, 16'd4, 16'd1);
        repeat (5) send_tick();
        send_item(OP_LOAD, 16'd0, 16'd2);
        repeat (8) send_tick();
        wait_for_reports();
    endtask

    task automatic test_random_schedule(input int count);
        int               pick;
        logic [ARR_W-1:0] arr;
        logic [BUR_W-1:0] bur;
        for (int n = 0; n < count; n++) begin
            idle_pct = (n < 400) ? 0 : 38;
            pick = $urandom_range(99);
            if (pick < 1 && jobs_held < MAX_PROCS - 2) begin
                if ($urandom_range(3) == 0) begin
                    arr = (cur_time > 50) ? ARR_W'(cur_time - $urandom_range(1, 50)) : '0;
                end else begin
                    arr = ARR_W'(cur_time + $urandom_range(0, 40));
                end
                bur = $urandom_range(1) ? BUR_W'($urandom_range(1, 8))
                                        : BUR_W'($urandom_range(9, 200));
                send_item(OP_LOAD, arr, bur);
            end else if (pick < 6) begin
                send_item(OP_LOAD, ARR_W'($urandom), '0);
            end else begin
                send_tick();
            end
        end
    endtask

    // last two slots, including one job that never becomes ready, then dropped loads
    task automatic test_full_table();
        while (jobs_held < MAX_PROCS - 2) begin
            send_item(OP_LOAD, ARR_W'(cur_time), BUR_W'($urandom_range(1, 6)));
        end
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
        send_item(OP_LOAD, ARR_W'(cur_time), 16'd3);
        send_item(OP_LOAD, 16'hFFFF, 16'hFFFF);
        for (int n = 0; n < 60; n++) begin
            if ($urandom_range(3) == 0) begin
                send_item(OP_LOAD, ARR_W'($urandom), BUR_W'($urandom));
            end else begin
                send_tick();
            end
        end
    endtask

    initial begin
        for (int s = 0; s < MAX_PROCS; s++) begin
            arrival_tab[s] = '0;
            burst_tab[s]   = '0;
            left_tab[s]    = '0;
        end
        jobs_held = 0;
        jobs_done = 0;
        cur_time  = '0;
        idle_pct  = 38;
        errors    = 0;
        loads_sent   = 0;
        ticks_sent   = 0;
        idle_ticks   = 0;
        reports_seen = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_preemption();
        test_random_schedule(1900);
        test_full_table();

        wait_for_reports();
        repeat (40) @(posedge i_clk);

        $display("covered %0d loads into %0d slots and %0d ticks (%0d idle), %0d jobs finished",
                 loads_sent, jobs_held, ticks_sent, idle_ticks, jobs_done);
        $display("%0d results checked", reports_seen);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
